// File: hw/rtl/rbst_pkg.sv
// Package for the ray versus box slab test: register index codes and the
// stage advance struct shared by the top level and the per-axis datapath.
// No dependencies.
`timescale 1ns / 1ps

package rbst_pkg;

    // Register file layout
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_BOX_LOW_X  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_LOW_Y  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_LOW_Z  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_HIGH_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BOX_HIGH_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BOX_HIGH_Z = 3'd5;

    // Load enables for the three stages of the per-axis datapath
    typedef struct packed {
        logic diff;
        logic mult;
        logic order;
    } rbst_adv_t;

endpackage

// File: hw/rtl/rbst_if.sv
// Stream interfaces for the slab test: ray requests in, hit results out.
// Valid/ready handshake; no package dependencies.
`timescale 1ns / 1ps

interface rbst_ray_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] recip_dir_x;
    logic signed [COORD_BITS-1:0] recip_dir_y;
    logic signed [COORD_BITS-1:0] recip_dir_z;

    modport source (
        output valid, start_x, start_y, start_z, recip_dir_x, recip_dir_y, recip_dir_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, recip_dir_x, recip_dir_y, recip_dir_z,
        output ready
    );
endinterface

interface rbst_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );
    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

// File: hw/rtl/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test. A request passes through 8 register
// stages from acceptance to result valid. Throughput: one request
// per cycle; valid bits travel with the data, a stalled output holds only the
// full stages behind it, and empty stages keep loading so bubbles close up.
// Reset clears the stage valid bits and sets all six box corner registers to 0.
// Depends on rbst_pkg, rbst_if (interfaces) and rbst_axis.
`timescale 1ns / 1ps

module ray_box_slab_test #(
    parameter int COORD_BITS = 32,
    localparam int PDATA_W  = (COORD_BITS > 32) ? 64 : 32,
    localparam int ADDR_LSB = (COORD_BITS > 32) ? 3 : 2,
    localparam int PADDR_W  = ADDR_LSB + rbst_pkg::REG_IDX_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rbst_ray_if.sink           ray,
    rbst_hit_if.source         result
);
    import rbst_pkg::*;

    localparam int PROD_W = 2 * COORD_BITS + 1;
    localparam int NS     = 8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [REG_IDX_W-1:0]         idx;
    logic                         idx_ok;
    logic                         wr_en;
    logic signed [COORD_BITS-1:0] box_reg [NUM_REGS];

    assign idx    = paddr[PADDR_W-1:ADDR_LSB];
    assign idx_ok = idx < REG_IDX_W'(NUM_REGS);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Write the addressed corner; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else if (wr_en && idx_ok)
        begin
            box_reg[idx] <= pwdata[COORD_BITS-1:0];
        end
    end

    // Return the addressed corner, zero beyond the list
    always_comb
    begin
        prdata = '0;
        if (idx_ok)
        begin
            prdata[COORD_BITS-1:0] = box_reg[idx];
        end
    end

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    rbst_adv_t     adv;

    // A stage loads when it is empty or the one after it loads
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || result.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= ray.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign ray.ready = en[0];
    assign adv       = '{diff: en[0], mult: en[1], order: en[2]};

    // ------------------------------------------------------------------
    // Per-axis distances (stages 0 to 2)
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] near_x, far_x, near_y, far_y, near_z, far_z;

    rbst_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .clk  (clk),
        .adv  (adv),
        .org  (ray.start_x),
        .inv  (ray.recip_dir_x),
        .lo   (box_reg[REG_BOX_LOW_X]),
        .hi   (box_reg[REG_BOX_HIGH_X]),
        .near (near_x),
        .far  (far_x)
    );

    rbst_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .clk  (clk),
        .adv  (adv),
        .org  (ray.start_y),
        .inv  (ray.recip_dir_y),
        .lo   (box_reg[REG_BOX_LOW_Y]),
        .hi   (box_reg[REG_BOX_HIGH_Y]),
        .near (near_y),
        .far  (far_y)
    );

    rbst_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
        .clk  (clk),
        .adv  (adv),
        .org  (ray.start_z),
        .inv  (ray.recip_dir_z),
        .lo   (box_reg[REG_BOX_LOW_Z]),
        .hi   (box_reg[REG_BOX_HIGH_Z]),
        .near (near_z),
        .far  (far_z)
    );

    // ------------------------------------------------------------------
    // Slab fold (stages 3 to 6) and hit decision (stage 7)
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] e1_next, e1_reg, fx3_reg, fy3_reg, nz3_reg, fz3_reg;
    logic signed [PROD_W-1:0] l1_next, l1_reg, e1_4_reg, nz4_reg, fz4_reg;
    logic signed [PROD_W-1:0] e2_next, e2_reg, l1_5_reg, fz5_reg;
    logic signed [PROD_W-1:0] l2_next, l2_reg, e2_6_reg;
    logic signed [PROD_W-1:0] t_ny, t_fy, t_nz, t_fz;
    logic                     hit_next, hit_reg;

    // Entry after y: max(near x, min(near y, far x))
    assign t_ny    = (near_y < far_x) ? near_y : far_x;
    assign e1_next = (near_x < t_ny) ? t_ny : near_x;

    // Exit after y: min(far x, max(far y, entry))
    assign t_fy    = (fy3_reg < e1_reg) ? e1_reg : fy3_reg;
    assign l1_next = (t_fy < fx3_reg) ? t_fy : fx3_reg;

    // Entry after z: max(entry, min(near z, exit))
    assign t_nz    = (nz4_reg < l1_reg) ? nz4_reg : l1_reg;
    assign e2_next = (e1_4_reg < t_nz) ? t_nz : e1_4_reg;

    // Exit after z: min(exit, max(far z, entry))
    assign t_fz    = (fz5_reg < e2_reg) ? e2_reg : fz5_reg;
    assign l2_next = (t_fz < l1_5_reg) ? t_fz : l1_5_reg;

    // Hit when exit lies beyond both entry and zero
    assign hit_next = (e2_6_reg < l2_reg) && !l2_reg[PROD_W-1] && (l2_reg != '0);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            e1_reg  <= e1_next;
            fx3_reg <= far_x;
            fy3_reg <= far_y;
            nz3_reg <= near_z;
            fz3_reg <= far_z;
        end
        if (en[4])
        begin
            l1_reg   <= l1_next;
            e1_4_reg <= e1_reg;
            nz4_reg  <= nz3_reg;
            fz4_reg  <= fz3_reg;
        end
        if (en[5])
        begin
            e2_reg   <= e2_next;
            l1_5_reg <= l1_reg;
            fz5_reg  <= fz4_reg;
        end
        if (en[6])
        begin
            l2_reg   <= l2_next;
            e2_6_reg <= e2_reg;
        end
        if (en[7])
        begin
            hit_reg <= hit_next;
        end
    end

    assign result.valid = vld_reg[NS-1];
    assign result.hit   = hit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic in_fire, out_fire;

    assign in_fire  = ray.valid && ray.ready;
    assign out_fire = result.valid && result.ready;

    // Back-pressure only when every stage is full and the output is stalled
    a_ready_full : assert property (@(posedge clk) disable iff (!rst_n)
        !ray.ready |-> (&vld_reg) && !result.ready)
        else $error("input stalled while a stage was free");

    // A request entering without one leaving adds one item in flight
    a_count_up : assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && in_fire && !out_fire |=>
        $countones(vld_reg) == $past($countones(vld_reg)) + 1)
        else $error("request lost or duplicated in pipeline");

    // A result leaving without a new request removes one item in flight
    a_count_down : assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && !in_fire && out_fire |=>
        $countones(vld_reg) + 1 == $past($countones(vld_reg)))
        else $error("result lost or duplicated in pipeline");

    // A held fold stage keeps its entry distance
    a_fold_hold : assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && vld_reg[3] && !en[3] |=> $stable(e1_reg))
        else $error("stalled fold stage changed");

endmodule

// File: hw/rtl/rbst_axis.sv
// Per-axis datapath of the slab test: corner minus origin, full-width product
// with the inverse direction, then ordering into near and far distances.
// Depends on rbst_pkg for the stage advance struct.
`timescale 1ns / 1ps

module rbst_axis #(
    parameter int COORD_BITS = 32,
    localparam int PROD_W = 2 * COORD_BITS + 1
) (
    input  logic                         clk,
    input  rbst_pkg::rbst_adv_t          adv,
    input  logic signed [COORD_BITS-1:0] org,
    input  logic signed [COORD_BITS-1:0] inv,
    input  logic signed [COORD_BITS-1:0] lo,
    input  logic signed [COORD_BITS-1:0] hi,
    output logic signed [PROD_W-1:0]     near,
    output logic signed [PROD_W-1:0]     far
);
    import rbst_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;

    logic signed [DIFF_W-1:0]     dlo_next, dhi_next;
    logic signed [DIFF_W-1:0]     dlo_reg, dhi_reg;
    logic signed [COORD_BITS-1:0] inv_reg;
    logic signed [PROD_W-1:0]     plo_next, phi_next;
    logic signed [PROD_W-1:0]     plo_reg, phi_reg;
    logic                         swap;
    logic signed [PROD_W-1:0]     near_next, far_next;
    logic signed [PROD_W-1:0]     near_reg, far_reg;

    // Differences are exact one bit wider than the coordinates
    assign dlo_next = DIFF_W'(lo) - DIFF_W'(org);
    assign dhi_next = DIFF_W'(hi) - DIFF_W'(org);

    always_ff @(posedge clk)
    begin
        if (adv.diff)
        begin
            dlo_reg <= dlo_next;
            dhi_reg <= dhi_next;
            inv_reg <= inv;
        end
    end

    // Full-width signed products, no rounding
    assign plo_next = PROD_W'(dlo_reg) * PROD_W'(inv_reg);
    assign phi_next = PROD_W'(dhi_reg) * PROD_W'(inv_reg);

    always_ff @(posedge clk)
    begin
        if (adv.mult)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
    end

    // Order the two distances
    assign swap      = phi_reg < plo_reg;
    assign near_next = swap ? phi_reg : plo_reg;
    assign far_next  = swap ? plo_reg : phi_reg;

    always_ff @(posedge clk)
    begin
        if (adv.order)
        begin
            near_reg <= near_next;
            far_reg  <= far_next;
        end
    end

    assign near = near_reg;
    assign far  = far_reg;

endmodule
